### src/xtat_pkg.sv
// Package for the markup tag tokenizer: scan modes, event codes, character
// constants, the event word type and default length limits. No dependencies.
package xtat_pkg;

  localparam int TAG_CHARS_DEF   = 16;
  localparam int NAME_CHARS_DEF  = 16;
  localparam int VALUE_CHARS_DEF = 16;

  // Output queue: room for two words per byte plus words still waiting.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  typedef enum logic [3:0] {
    MODE_WAIT  = 4'b0001,
    MODE_TAG   = 4'b0010,
    MODE_NAME  = 4'b0100,
    MODE_VALUE = 4'b1000
  } mode_t;

  typedef enum logic [2:0] {
    EV_TAG_BEGIN  = 3'd0,
    EV_TAG_CHAR   = 3'd1,
    EV_TAG_DONE   = 3'd2,
    EV_NAME_CHAR  = 3'd3,
    EV_NAME_DONE  = 3'd4,
    EV_VALUE_CHAR = 3'd5,
    EV_ATTR_DONE  = 3'd6,
    EV_ELEM_DONE  = 3'd7
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  ch;
    logic [3:0]  idx;
    logic        last;
  } ev_t;

  function automatic ev_t mk_ev(ev_kind_t kind, logic [7:0] ch, logic [3:0] idx);
    ev_t e;
    e.kind = kind;
    e.ch   = ch;
    e.idx  = idx;
    e.last = 1'b0;
    return e;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

endpackage

### src/xtat_if.sv
// Stream interfaces for the markup tag tokenizer: raw byte input and event
// output, each with valid/ready. No dependencies.
interface xtat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface xtat_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] char_out;
  logic [3:0] char_index;
  logic       last_event;

  modport source (output valid, output event_kind, output char_out,
                  output char_index, output last_event, input ready);
  modport sink   (input valid, input event_kind, input char_out,
                  input char_index, input last_event, output ready);
endinterface

### src/xml_tag_attribute_tokenizer_core.sv
// Top level of the markup tag tokenizer: scan state and output event queue.
// Depends on xtat_pkg and the stream interfaces in xtat_if.sv.
//
// The core takes one raw byte per word on in_if and reports token events on
// out_if, one event per word: tag begin, tag name characters, tag name done,
// attribute name characters, name done at '=', value characters, attribute
// done and element done at '>'. Every character event carries its position
// in char_index, and last_event flags the final event of each byte. A byte
// is scanned in the cycle it is accepted, so one byte enters per cycle while
// the queue has room; the figure is set by the output side, which moves one
// event per cycle while out_if.ready is high, from a four-word queue. A byte
// is taken whenever the queue has room for two events, so a stream in which
// most bytes give at most one event runs at one byte per cycle if out_if is
// ready; a byte giving two events ('>' closing a tag name or a value) leaves
// one more word to drain. Characters beyond TAG_CHARS-1, NAME_CHARS-1 or
// VALUE_CHARS-1 in one name or value are dropped without an event.
module xml_tag_attribute_tokenizer_core
  import xtat_pkg::*;
#(
  parameter int TAG_CHARS   = TAG_CHARS_DEF,
  parameter int NAME_CHARS  = NAME_CHARS_DEF,
  parameter int VALUE_CHARS = VALUE_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  xtat_in_if.sink    in_if,
  xtat_out_if.source out_if
);

  localparam int TW = $clog2(TAG_CHARS);
  localparam int NW = $clog2(NAME_CHARS);
  localparam int VW = $clog2(VALUE_CHARS);

  // Scan state
  mode_t          mode_r, mode_nxt;
  logic [TW-1:0]  tag_cnt_r, tag_cnt_nxt;
  logic [NW-1:0]  name_cnt_r, name_cnt_nxt;
  logic [VW-1:0]  value_cnt_r, value_cnt_nxt;
  logic           quoted_r, quoted_nxt;

  // Event queue
  ev_t               queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  logic       in_acc, out_pop;
  logic [1:0] n_ev;
  ev_t        ev0, ev1;
  logic [7:0] c;

  assign c        = in_if.in_byte;
  // Take a byte only when two more events fit.
  assign in_if.ready = (cnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign in_acc   = in_if.valid && in_if.ready;
  assign out_if.valid = (cnt_r != '0);
  assign out_pop  = out_if.valid && out_if.ready;

  // One scan step for the byte at the input.
  always_comb begin
    mode_nxt      = mode_r;
    tag_cnt_nxt   = tag_cnt_r;
    name_cnt_nxt  = name_cnt_r;
    value_cnt_nxt = value_cnt_r;
    quoted_nxt    = quoted_r;
    n_ev          = 2'd0;
    ev0           = mk_ev(EV_TAG_BEGIN, 8'h00, 4'h0);
    ev1           = mk_ev(EV_TAG_BEGIN, 8'h00, 4'h0);

    if (c == CH_LT) begin
      // '<' opens a new tag from any mode
      mode_nxt      = MODE_TAG;
      tag_cnt_nxt   = '0;
      value_cnt_nxt = '0;
      n_ev          = 2'd1;
    end else begin
      unique case (mode_r)
        MODE_TAG: begin
          if (c == CH_GT) begin
            if (tag_cnt_r != '0) begin
              ev0  = mk_ev(EV_TAG_DONE, 8'h00, 4'h0);
              ev1  = mk_ev(EV_ELEM_DONE, 8'h00, 4'h0);
              n_ev = 2'd2;
            end else begin
              ev0  = mk_ev(EV_ELEM_DONE, 8'h00, 4'h0);
              n_ev = 2'd1;
            end
            mode_nxt      = MODE_WAIT;
            tag_cnt_nxt   = '0;
            value_cnt_nxt = '0;
          end else if (is_blank(c)) begin
            // a blank before the first character is ignored
            if (tag_cnt_r != '0) begin
              mode_nxt     = MODE_NAME;
              name_cnt_nxt = '0;
              tag_cnt_nxt  = '0;
              ev0          = mk_ev(EV_TAG_DONE, 8'h00, 4'h0);
              n_ev         = 2'd1;
            end
          end else if (tag_cnt_r < TW'(TAG_CHARS - 1)) begin
            ev0         = mk_ev(EV_TAG_CHAR, c, 4'(tag_cnt_r));
            n_ev        = 2'd1;
            tag_cnt_nxt = tag_cnt_r + 1'b1;
          end
        end
        MODE_NAME: begin
          if (c == CH_GT) begin
            ev0           = mk_ev(EV_ELEM_DONE, 8'h00, 4'h0);
            n_ev          = 2'd1;
            mode_nxt      = MODE_WAIT;
            value_cnt_nxt = '0;
          end else if (c == CH_DQ || c == CH_SQ || is_blank(c)) begin
            // drop quotes and blanks inside a name
          end else if (c == CH_EQ) begin
            mode_nxt      = MODE_VALUE;
            value_cnt_nxt = '0;
            quoted_nxt    = 1'b0;
            ev0           = mk_ev(EV_NAME_DONE, 8'h00, 4'h0);
            n_ev          = 2'd1;
          end else if (name_cnt_r < NW'(NAME_CHARS - 1)) begin
            ev0          = mk_ev(EV_NAME_CHAR, c, 4'(name_cnt_r));
            n_ev         = 2'd1;
            name_cnt_nxt = name_cnt_r + 1'b1;
          end
        end
        MODE_VALUE: begin
          if (c == CH_GT) begin
            if (value_cnt_r != '0) begin
              ev0  = mk_ev(EV_ATTR_DONE, 8'h00, 4'h0);
              ev1  = mk_ev(EV_ELEM_DONE, 8'h00, 4'h0);
              n_ev = 2'd2;
            end else begin
              ev0  = mk_ev(EV_ELEM_DONE, 8'h00, 4'h0);
              n_ev = 2'd1;
            end
            mode_nxt      = MODE_WAIT;
            value_cnt_nxt = '0;
          end else if (c == CH_DQ || c == CH_SQ) begin
            quoted_nxt = !quoted_r;
          end else if (!quoted_r && (is_blank(c) || c == CH_SLASH)) begin
            // unquoted delimiter closes the value, even an empty one
            mode_nxt      = MODE_NAME;
            name_cnt_nxt  = '0;
            value_cnt_nxt = '0;
            ev0           = mk_ev(EV_ATTR_DONE, 8'h00, 4'h0);
            n_ev          = 2'd1;
          end else if (c == CH_EQ || is_blank(c)) begin
            // drop '=' and blanks inside a quoted value
          end else if (value_cnt_r < VW'(VALUE_CHARS - 1)) begin
            ev0           = mk_ev(EV_VALUE_CHAR, c, 4'(value_cnt_r));
            n_ev          = 2'd1;
            value_cnt_nxt = value_cnt_r + 1'b1;
          end
        end
        default: begin
          // waiting, or a code that is never reached: ignore the byte
          mode_nxt = MODE_WAIT;
        end
      endcase
    end

    // flag the final event of this byte
    if (n_ev == 2'd1) begin
      ev0.last = 1'b1;
    end
    if (n_ev == 2'd2) begin
      ev1.last = 1'b1;
    end
  end

  // Advance scan state on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_WAIT;
      tag_cnt_r   <= '0;
      name_cnt_r  <= '0;
      value_cnt_r <= '0;
      quoted_r    <= 1'b0;
    end else if (in_acc) begin
      mode_r      <= mode_nxt;
      tag_cnt_r   <= tag_cnt_nxt;
      name_cnt_r  <= name_cnt_nxt;
      value_cnt_r <= value_cnt_nxt;
      quoted_r    <= quoted_nxt;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(n_ev);
      end
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (in_acc ? QCNT_W'(n_ev) : '0) - QCNT_W'(out_pop);
    end
  end

  // Queue storage: payload only, no reset.
  always_ff @(posedge clk) begin
    if (in_acc && n_ev != 2'd0) begin
      queue_r[wr_ptr_r] <= ev0;
    end
    if (in_acc && n_ev == 2'd2) begin
      queue_r[wr_ptr_r + 1'b1] <= ev1;
    end
  end

  assign out_if.event_kind = queue_r[rd_ptr_r].kind;
  assign out_if.char_out   = queue_r[rd_ptr_r].ch;
  assign out_if.char_index = queue_r[rd_ptr_r].idx;
  assign out_if.last_event = queue_r[rd_ptr_r].last;

  // Fill count never passes the queue depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("event queue overfilled");

  // '<' always opens a tag.
  a_lt_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && c == CH_LT) |=> (mode_r == MODE_TAG && tag_cnt_r == '0))
    else $error("'<' did not open a tag");

  // '<' queues exactly one event.
  a_lt_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && c == CH_LT) |=>
      (cnt_r == $past(cnt_r) + QCNT_W'(1) - QCNT_W'($past(out_pop))))
    else $error("'<' queued a wrong number of events");

  // Kept tag characters stay within the limit.
  a_tag_limit: assert property (@(posedge clk) disable iff (!rst_n)
    tag_cnt_r <= TW'(TAG_CHARS - 1))
    else $error("tag name counter past its limit");

endmodule

### dv/tb_top.sv
// Testbench for the markup tag tokenizer core: byte words in, token event words out.
// Depends on xtat_pkg and the stream interfaces of xtat_if.sv; predicts every event
// from its own scan state and checks each output word in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xtat_pkg::*;

  // Cycles with no word moving on either side before the run is called hung.
  localparam int unsigned STALL_LIMIT = 4000;
  // Length of the long receiver hold-off that fills the event queue.
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LIVE_TARGET = 1200;

  logic clk;
  logic rst_n;

  xtat_in_if  in_bus();
  xtat_out_if out_bus();

  xml_tag_attribute_tokenizer_core #(
    .TAG_CHARS  (TAG_CHARS_DEF),
    .NAME_CHARS (NAME_CHARS_DEF),
    .VALUE_CHARS(VALUE_CHARS_DEF)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus)
  );

  // Scan state of the predictor.
  mode_t       scan_state;
  int unsigned tag_len;
  int unsigned attr_name_len;
  int unsigned attr_value_len;
  bit          in_quotes;

  // Events still owed by the core, oldest first, and the events of the byte
  // being scanned right now.
  ev_t pending_events[$];
  ev_t byte_events[$];

  int unsigned fail_count;
  int unsigned live_bytes;    // bytes the core does not simply skip
  int unsigned burst_left;
  int unsigned idle_cycles;
  bit          sender_gaps;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void note_event(ev_kind_t kind, logic [7:0] ch, int unsigned pos);
    ev_t e;
    e.kind = kind;
    e.ch   = ch;
    e.idx  = 4'(pos);
    e.last = 1'b0;
    byte_events.push_back(e);
  endfunction

  // Advance the scan state by one accepted byte and queue the events it causes.
  function automatic void tokenize_byte(logic [7:0] c);
    bit blank;
    blank = (c == CH_SP) || (c == CH_TAB);
    if (c == CH_LT || scan_state != MODE_WAIT)
      live_bytes++;

    if (c == CH_LT) begin
      // '<' always opens a fresh tag, wherever the scan stands; the value
      // count is cleared so an aborted attribute never resurfaces.
      scan_state     = MODE_TAG;
      tag_len        = 0;
      attr_value_len = 0;
      note_event(EV_TAG_BEGIN, 8'h00, 0);
    end else begin
      case (scan_state)
        MODE_TAG: begin
          if (c == CH_GT) begin
            if (tag_len != 0)
              note_event(EV_TAG_DONE, 8'h00, 0);
            note_event(EV_ELEM_DONE, 8'h00, 0);
            scan_state     = MODE_WAIT;
            tag_len        = 0;
            attr_value_len = 0;
          end else if (blank) begin
            // A blank ahead of the first tag character is skipped.
            if (tag_len != 0) begin
              scan_state    = MODE_NAME;
              attr_name_len = 0;
              tag_len       = 0;
              note_event(EV_TAG_DONE, 8'h00, 0);
            end
          end else if (tag_len < TAG_CHARS_DEF - 1) begin
            // Quotes are ordinary characters inside a tag name.
            note_event(EV_TAG_CHAR, c, tag_len);
            tag_len++;
          end
        end
        MODE_NAME: begin
          if (c == CH_GT) begin
            note_event(EV_ELEM_DONE, 8'h00, 0);
            scan_state     = MODE_WAIT;
            attr_value_len = 0;
          end else if (c == CH_DQ || c == CH_SQ || blank) begin
            // drop quotes and blanks in attribute names
          end else if (c == CH_EQ) begin
            scan_state     = MODE_VALUE;
            attr_value_len = 0;
            in_quotes      = 1'b0;
            note_event(EV_NAME_DONE, 8'h00, 0);
          end else if (attr_name_len < NAME_CHARS_DEF - 1) begin
            note_event(EV_NAME_CHAR, c, attr_name_len);
            attr_name_len++;
          end
        end
        MODE_VALUE: begin
          if (c == CH_GT) begin
            // An empty value at '>' reports only the element end.
            if (attr_value_len != 0)
              note_event(EV_ATTR_DONE, 8'h00, 0);
            note_event(EV_ELEM_DONE, 8'h00, 0);
            scan_state     = MODE_WAIT;
            attr_value_len = 0;
          end else if (c == CH_DQ || c == CH_SQ) begin
            in_quotes = !in_quotes;
          end else if (!in_quotes && (blank || c == CH_SLASH)) begin
            // An unquoted delimiter ends the attribute even when it is empty.
            scan_state     = MODE_NAME;
            attr_name_len  = 0;
            attr_value_len = 0;
            note_event(EV_ATTR_DONE, 8'h00, 0);
          end else if (c == CH_EQ || blank) begin
            // drop '=' and blanks inside a quoted value
          end else if (attr_value_len < VALUE_CHARS_DEF - 1) begin
            note_event(EV_VALUE_CHAR, c, attr_value_len);
            attr_value_len++;
          end
        end
        default: scan_state = MODE_WAIT;
      endcase
    end

    // Flag the final event of this byte, then hand all of them to the checker.
    if (byte_events.size() > 0)
      byte_events[byte_events.size() - 1].last = 1'b1;
    foreach (byte_events[i])
      pending_events.push_back(byte_events[i]);
    byte_events.delete();
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender: bursts of random length with random gaps between them
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (sender_gaps && burst_left == 0) begin
      // Drop valid and scramble the payload so the core must ignore it.
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      in_bus.valid   <= 1'b0;
      in_bus.in_byte <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0)
      burst_left--;
    in_bus.valid   <= 1'b1;
    in_bus.in_byte <= b;
    // Hold the word until the core takes it.
    do @(posedge clk); while (!in_bus.ready);
    tokenize_byte(b);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus shaping
  // ---------------------------------------------------------------------------

  // A character with no markup meaning; bytes above 127 are kept on purpose.
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_SLASH || c == CH_SP ||
        c == CH_TAB || c == CH_DQ || c == CH_SQ)
      c = 8'h41 + 8'($urandom_range(0, 25));
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? CH_SP : CH_TAB;
  endfunction

  // Mostly short fields; now and then a long one that can run past the length limit.
  function automatic int unsigned field_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
  endfunction

  // One tag with random content. Some tags are cut off inside their last
  // value so that the next '<' has to discard a half-built attribute.
  task automatic send_tag();
    int unsigned n_attr;
    int unsigned len;
    bit          broken;
    bit          last_attr;
    logic [7:0]  quote;
    broken = ($urandom_range(0, 7) == 0);
    send_byte(CH_LT);
    if ($urandom_range(0, 3) == 0)
      send_byte(pick_blank());
    len = ($urandom_range(0, 9) == 0) ? 0 : field_len();
    for (int i = 0; i < len; i++)
      send_byte(($urandom_range(0, 11) == 0) ? CH_DQ : text_char());
    n_attr = $urandom_range(0, 3);
    if (n_attr == 0) begin
      send_byte(CH_GT);
      return;
    end
    send_byte(pick_blank());
    for (int a = 0; a < n_attr; a++) begin
      last_attr = (a == n_attr - 1);
      if ($urandom_range(0, 5) == 0)
        send_byte(pick_blank());
      len = ($urandom_range(0, 9) == 0) ? 0 : field_len();
      for (int i = 0; i < len; i++)
        send_byte(($urandom_range(0, 11) == 0) ? CH_SQ : text_char());
      send_byte(CH_EQ);
      len = ($urandom_range(0, 7) == 0) ? 0 : field_len();
      if ($urandom_range(0, 1)) begin
        // Quoted value: blanks and '=' inside are dropped, '/' is kept; none are delimiters.
        quote = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
        send_byte(quote);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 7))
            0:       send_byte(pick_blank());
            1:       send_byte(CH_EQ);
            2:       send_byte(CH_SLASH);
            default: send_byte(text_char());
          endcase
        end
        if (broken && last_attr)
          return;
        send_byte(quote);
      end else begin
        for (int i = 0; i < len; i++)
          send_byte(text_char());
        if (broken && last_attr)
          return;
      end
      if (last_attr && $urandom_range(0, 1)) begin
        send_byte(CH_GT);
      end else begin
        case ($urandom_range(0, 2))
          0:       send_byte(CH_SP);
          1:       send_byte(CH_TAB);
          default: send_byte(CH_SLASH);
        endcase
        if (last_attr)
          send_byte(CH_GT);
      end
    end
  endtask

  // Raw bytes between tags; a stray '<' in here opens a junk tag.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_markup_until(input int unsigned target);
    while (live_bytes < target) begin
      if ($urandom_range(0, 2) == 0)
        send_noise();
      send_tag();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked stream: skipped bytes while waiting, the byte extremes, a
  // blank ahead of the tag name, quote handling in names and values, dropped
  // '=' and blanks in quoted values, empty name and empty value, a delimiter
  // on an empty value, and '>' closing both a value and a bare tag name.
  task automatic test_directed();
    logic [7:0] stream[$];
    stream = '{8'hFF, CH_GT, CH_LT, CH_TAB, 8'h61, 8'h00, CH_SP,
               8'h6E, CH_SQ, CH_EQ, CH_DQ, 8'h76, CH_SP, CH_EQ, CH_DQ, CH_SLASH,
               CH_EQ, CH_TAB, 8'h6B, CH_EQ, 8'h78, CH_GT,
               CH_LT, 8'h62, CH_GT};
    foreach (stream[i])
      send_byte(stream[i]);
  endtask

  // Random markup with gaps on the input side.
  task automatic test_random_markup();
    sender_gaps = 1'b1;
    send_markup_until(live_bytes + 600);
  endtask

  // Receiver holds off for a long stretch while bytes keep coming, so the
  // event queue fills and the core must stall its input.
  task automatic test_backpressure();
    int unsigned target;
    target      = live_bytes + 80;
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    send_markup_until(target);
  endtask

  // Back-to-back bytes for the rest of the run.
  task automatic test_stream_no_gaps();
    sender_gaps = 1'b0;
    send_markup_until(LIVE_TARGET);
  endtask

  // ---------------------------------------------------------------------------
  // Event receiver: ready follows styles of random length, except during a
  // requested hold-off
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned style;
    int unsigned style_left;
    style      = 0;
    style_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 2);
          style_left = $urandom_range(8, 64);
        end
        style_left--;
        case (style)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          default: out_bus.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output word against the oldest owed event
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_events
    ev_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event word: event_kind %0d char_out %0h char_index %0d",
               out_bus.event_kind, out_bus.char_out, out_bus.char_index);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_bus.event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, out_bus.event_kind);
          fail_count++;
        end
        if (out_bus.char_out !== want.ch) begin
          $error("char_out: expected %0h, got %0h", want.ch, out_bus.char_out);
          fail_count++;
        end
        if (out_bus.char_index !== want.idx) begin
          $error("char_index: expected %0d, got %0d", want.idx, out_bus.char_index);
          fail_count++;
        end
        if (out_bus.last_event !== want.last) begin
          $error("last_event: expected %0d, got %0d", want.last, out_bus.last_event);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    scan_state     = MODE_WAIT;
    tag_len        = 0;
    attr_name_len  = 0;
    attr_value_len = 0;
    in_quotes      = 1'b0;
    fail_count     = 0;
    live_bytes     = 0;
    burst_left     = 0;
    idle_cycles    = 0;
    sender_gaps    = 1'b1;
    hold_req       = 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.in_byte <= 8'h00;
    rst_n          <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_markup();
    test_backpressure();
    test_stream_no_gaps();

    // Drain: wait for every owed event, then a margin for stray words.
    in_bus.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

### sim.f
src/xtat_pkg.sv
src/xtat_if.sv
src/xml_tag_attribute_tokenizer_core.sv
dv/tb_top.sv
